[rtl/bpsf_pkg.sv]
// Package with types, constants and register codes of the box point support filter.
`default_nettype none
package bpsf_pkg;
    localparam int MaxPoints = 4096;
    localparam int IdxW = $clog2(MaxPoints);
    localparam int CntW = IdxW + 1;

    typedef enum logic [1:0] {
        OP_FRAME = 2'd0,
        OP_PIXEL = 2'd1,
        OP_QUERY = 2'd2,
        OP_NONE  = 2'd3
    } t_opcode;

    localparam logic [2:0] REG_LOW_FLOOR  = 3'd0;
    localparam logic [2:0] REG_LOW_CEIL   = 3'd1;
    localparam logic [2:0] REG_HIGH_CEIL  = 3'd2;
    localparam logic [2:0] REG_MIN_SUP    = 3'd3;
    localparam logic [2:0] REG_DISP       = 3'd4;
    localparam logic [2:0] REG_IMG_WIDTH  = 3'd5;

    typedef struct packed {
        logic [1:0]         opcode;
        logic [11:0]        coord_x;
        logic [11:0]        coord_y;
        logic [11:0]        extent_w;
        logic [11:0]        extent_h;
        logic [15:0]        range_value;
        logic signed [15:0] low_height;
        logic signed [15:0] high_height;
    } t_in;

    typedef struct packed {
        logic               accepted;
        logic signed [15:0] min_height_out;
        logic signed [15:0] max_height_out;
        logic [12:0]        points_in_box;
        logic               store_overflow;
    } t_out;

    typedef struct packed {
        logic [11:0]        col;
        logic [11:0]        row;
        logic signed [15:0] low;
        logic signed [15:0] high;
    } t_point;

    // Sums handed from the point scan to the dispersion test.
    typedef struct packed {
        logic [CntW-1:0]    n;
        logic signed [31:0] s;
        logic [44:0]        q;
    } t_sums;
endpackage
`default_nettype wire

[rtl/bpsf_disp.sv]
// Multi-cycle exact dispersion test: 65536*(N*Q - S*S) >= (D*|S|)^2.
`default_nettype none
module bpsf_disp (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_start,
    input  wire bpsf_pkg::t_sums i_sums,
    input  wire logic [15:0]    i_disp,
    output logic                o_done,
    output logic                o_dispersed
);
    import bpsf_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_M1, S_M2, S_M3, S_CMP
    } t_state;

    t_state      r_state;
    logic [31:0] r_abs_s;
    logic [44:0] r_q;
    logic [CntW-1:0] r_n;
    logic [63:0] r_nq;
    logic [63:0] r_ss;
    logic [47:0] r_ds;
    logic [95:0] r_rhs;
    logic [63:0] r_var;
    logic        r_done;
    logic        r_disp_res;

    // Multiplies are spread over S_M1 to S_M3; wide ones are split in halves.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_abs_s <= i_sums.s[31] ? 32'(-i_sums.s) : 32'(i_sums.s);
                        r_q     <= i_sums.q;
                        r_n     <= i_sums.n;
                        r_state <= S_M1;
                    end
                end
                S_M1: begin
                    r_ss    <= 64'(r_abs_s) * 64'(r_abs_s);
                    r_ds    <= 48'(r_abs_s) * 48'(i_disp);
                    r_state <= S_M2;
                end
                S_M2: begin
                    r_nq    <= 64'(r_n) * 64'(r_q[22:0])
                             + ((64'(r_n) * 64'(r_q[44:23])) << 23);
                    r_rhs   <= 96'(96'(r_ds) * 96'(r_ds[23:0]));
                    r_state <= S_M3;
                end
                S_M3: begin
                    r_var   <= r_nq - r_ss;
                    r_rhs   <= r_rhs + ((96'(r_ds) * 96'(r_ds[47:24])) << 24);
                    r_state <= S_CMP;
                end
                S_CMP: begin
                    r_disp_res <= ({16'd0, r_var, 16'd0} >= r_rhs);
                    r_done     <= 1'b1;
                    r_state    <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_done      = r_done;
    assign o_dispersed = r_disp_res;
endmodule
`default_nettype wire

[rtl/box_point_support_filter.sv]
// Top level: point store, raster counting, box scan and result register.
// Pixels and frame starts are handled while idle; busy stays low for them.
// A box query scans point_count stored points at one read per cycle, then
// runs a four-step dispersion test; busy falls in the same cycle as the
// result strobe rises, which presents the registered query result.
// Synchronous active-low reset empties the store count, raster position
// and overflow flag and loads the register defaults; results cannot stall.
`default_nettype none
module box_point_support_filter (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            start,
    output logic                 busy,
    input  wire bpsf_pkg::t_in   i_data,
    output logic                 o_valid,
    output bpsf_pkg::t_out       o_data,
    input  wire logic            psel,
    input  wire logic            penable,
    input  wire logic            pwrite,
    input  wire logic [4:0]      paddr,
    input  wire logic [31:0]     pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);
    import bpsf_pkg::*;

    typedef enum logic [2:0] {S_IDLE, S_SCAN, S_DRAIN, S_DISP, S_OUT} t_state;

    // Configuration registers.
    logic signed [15:0] r_low_floor, r_low_ceil, r_high_ceil;
    logic [12:0] r_min_sup;
    logic [15:0] r_disp;
    logic [11:0] r_img_w;
    logic [2:0]  w_reg;
    assign w_reg  = paddr[4:2];
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low_floor <= -16'sd1500;
            r_low_ceil  <= -16'sd1000;
            r_high_ceil <= 16'sd2000;
            r_min_sup   <= 13'd2;
            r_disp      <= 16'd256;
            r_img_w     <= 12'd640;
        end else if (psel && penable && pwrite) begin
            unique case (w_reg)
                REG_LOW_FLOOR: r_low_floor <= pwdata[15:0];
                REG_LOW_CEIL:  r_low_ceil  <= pwdata[15:0];
                REG_HIGH_CEIL: r_high_ceil <= pwdata[15:0];
                REG_MIN_SUP:   r_min_sup   <= pwdata[12:0];
                REG_DISP:      r_disp      <= pwdata[15:0];
                REG_IMG_WIDTH: r_img_w     <= pwdata[11:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_reg)
            REG_LOW_FLOOR: prdata = 32'(signed'(r_low_floor));
            REG_LOW_CEIL:  prdata = 32'(signed'(r_low_ceil));
            REG_HIGH_CEIL: prdata = 32'(signed'(r_high_ceil));
            REG_MIN_SUP:   prdata = 32'(r_min_sup);
            REG_DISP:      prdata = 32'(r_disp);
            REG_IMG_WIDTH: prdata = 32'(r_img_w);
            default:       prdata = 32'd0;
        endcase
    end

    // Point store memory.
    t_point r_mem [MaxPoints];
    t_point r_rd;
    logic   w_we;
    logic [IdxW-1:0] w_waddr, w_raddr;
    t_point w_wdata;
    always_ff @(posedge i_clk) begin
        if (w_we) r_mem[w_waddr] <= w_wdata;
        r_rd <= r_mem[w_raddr];
    end

    t_state r_state;
    logic [CntW-1:0] r_count, r_idx;
    logic [11:0] r_col, r_row;
    logic r_ovf;
    logic [11:0] r_x0, r_y0;
    logic [12:0] r_x1, r_y1;
    logic [15:0] r_range;
    logic r_rd_vld;
    t_sums r_sums;
    logic signed [15:0] r_lo_min, r_hi_max;
    logic r_valid;
    t_out r_out;
    logic w_accept, w_disp_done, w_dispersed;
    logic [12:0] w_col_next, w_eff_w;

    assign w_accept   = start && !busy;
    assign busy       = (r_state != S_IDLE);
    assign w_we       = w_accept && i_data.opcode == OP_PIXEL && i_data.range_value != 16'd0
                        && r_count < CntW'(MaxPoints);
    assign w_waddr    = r_count[IdxW-1:0];
    assign w_wdata    = '{col: r_col, row: r_row, low: i_data.low_height,
                          high: i_data.high_height};
    assign w_raddr    = r_idx[IdxW-1:0];
    assign w_col_next = 13'(r_col) + 13'd1;
    assign w_eff_w    = (r_img_w == 12'd0) ? 13'd4096 : 13'(r_img_w);

    // Qualification of the point read in the previous cycle.
    logic w_in, w_q;
    assign w_in = 13'(r_rd.col) >= 13'(r_x0) && 13'(r_rd.col) < r_x1
               && 13'(r_rd.row) >= 13'(r_y0) && 13'(r_rd.row) < r_y1;
    assign w_q  = r_rd_vld && w_in && r_rd.low > r_low_floor && r_rd.low < r_low_ceil
               && r_rd.high < r_high_ceil;

    // The sums are final in the drain cycle, so the test starts there once.
    bpsf_disp u_disp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_state == S_DRAIN),
        .i_sums     (r_sums),
        .i_disp     (r_disp),
        .o_done     (w_disp_done),
        .o_dispersed(w_dispersed)
    );

    // Control, raster counting, scan accumulation and result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_col    <= '0;
            r_row    <= '0;
            r_ovf    <= 1'b0;
            r_valid  <= 1'b0;
            r_rd_vld <= 1'b0;
        end else begin
            r_valid  <= 1'b0;
            r_rd_vld <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        unique case (t_opcode'(i_data.opcode))
                            OP_FRAME: begin
                                r_count <= '0;
                                r_col   <= '0;
                                r_row   <= '0;
                                r_ovf   <= 1'b0;
                            end
                            OP_PIXEL: begin
                                if (i_data.range_value != 16'd0) begin
                                    if (r_count < CntW'(MaxPoints)) r_count <= r_count + 1'b1;
                                    else r_ovf <= 1'b1;
                                end
                                if (w_col_next >= w_eff_w) begin
                                    r_col <= '0;
                                    r_row <= r_row + 1'b1;
                                end else begin
                                    r_col <= w_col_next[11:0];
                                end
                            end
                            OP_QUERY: begin
                                r_x0     <= i_data.coord_x;
                                r_y0     <= i_data.coord_y;
                                r_x1     <= 13'(i_data.coord_x) + 13'(i_data.extent_w);
                                r_y1     <= 13'(i_data.coord_y) + 13'(i_data.extent_h);
                                r_range  <= i_data.range_value;
                                r_idx    <= '0;
                                r_sums   <= '0;
                                r_lo_min <= '0;
                                r_hi_max <= '0;
                                r_state  <= S_SCAN;
                            end
                            OP_NONE: ;
                            default: ;
                        endcase
                    end
                end
                S_SCAN: begin
                    if (r_idx < r_count) begin
                        r_rd_vld <= 1'b1;
                        r_idx    <= r_idx + 1'b1;
                    end else begin
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: r_state <= S_DISP;
                S_DISP: if (w_disp_done) r_state <= S_OUT;
                S_OUT: begin
                    r_out.accepted <= r_range != 16'd0 && 32'(r_sums.n) >= 32'(r_min_sup)
                                      && !w_dispersed;
                    r_out.min_height_out <= r_lo_min;
                    r_out.max_height_out <= r_hi_max;
                    r_out.points_in_box  <= (32'(r_sums.n) > 32'd8191) ? 13'd8191
                                                                      : 13'(r_sums.n);
                    r_out.store_overflow <= r_ovf;
                    r_valid <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
            if (w_q) begin
                r_sums.n <= r_sums.n + 1'b1;
                r_sums.s <= r_sums.s + 32'(r_rd.low);
                r_sums.q <= r_sums.q + 45'(32'(r_rd.low * r_rd.low));
                if (r_rd.low < r_lo_min) r_lo_min <= r_rd.low;
                if (r_rd.high > r_hi_max) r_hi_max <= r_rd.high;
            end
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_out;
endmodule
`default_nettype wire

[rtl/bpsf_check.sv]
// Port-level checker for the box point support filter, bound to the top level.
`default_nettype none
module bpsf_check (
    input wire logic          i_clk,
    input wire logic          i_rst_n,
    input wire logic          start,
    input wire logic          busy,
    input wire logic          o_valid,
    input wire bpsf_pkg::t_in i_data,
    input wire logic          pready
);
    import bpsf_pkg::*;

    // A query makes the block busy on the next cycle.
    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && i_data.opcode == OP_QUERY |=> busy)
        else $error("query did not raise busy");
    // A result ends the query: busy drops with it.
    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result while busy");
    // Results only follow a busy period.
    a_valid_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(busy))
        else $error("result without query");
    a_ready: assert property (@(posedge i_clk) pready)
        else $error("pready low");
endmodule

bind box_point_support_filter bpsf_check u_bpsf_check (
    .i_clk  (i_clk),
    .i_rst_n(i_rst_n),
    .start  (start),
    .busy   (busy),
    .o_valid(o_valid),
    .i_data (i_data),
    .pready (pready)
);
`default_nettype wire
